// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ffba_pkg.sv =====
package ffba_pkg;

    localparam int BC_W     = 5;
    localparam int BIDX_W   = 4;
    localparam int REQ_W    = 16;
    localparam int HOLE_W   = 20;

    localparam logic [HOLE_W-1:0] HOLE_MAX = {HOLE_W{1'b1}};

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== src/ffba_ram.sv =====
module ffba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit block allocator. A request is taken when start is high and busy is low; busy
// then stays high until the single result has been shown. The result appears on
// o_granted, o_block_number and o_hole_total for exactly one cycle, marked by o_done, and
// must be captured in that cycle. A load request writes one table entry (if its index is
// in range) and then rescans the table to rebuild the hole total; an allocate request
// scans the table from entry 0. The scan reads one entry per cycle through the single
// read port of the free-space RAM, then waits for the last read to land and closes the
// scan before o_done is raised. The number of blocks in use is the minimum of
// block_count and NUM_BLOCKS. busy drops in the cycle after o_done, and the next request
// can be taken from that cycle on. Reset clears the table through per-entry valid bits,
// so the block is ready in the cycle after reset. block_count is written through the cfg
// channel, which is always ready; write it only while busy is low.
`include "assert_macros.svh"

module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [ffba_pkg::BIDX_W-1:0]   i_block_index,
    input  logic [ffba_pkg::REQ_W-1:0]    i_size,
    output logic                          o_done,
    output logic                          o_granted,
    output logic [ffba_pkg::BIDX_W-1:0]   o_block_number,
    output logic [ffba_pkg::HOLE_W-1:0]   o_hole_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffba_pkg::BC_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CMP_W = (SIZE_BITS > ffba_pkg::REQ_W) ? SIZE_BITS : ffba_pkg::REQ_W;
    localparam int SUM_W = ((SIZE_BITS > ffba_pkg::HOLE_W) ? SIZE_BITS : ffba_pkg::HOLE_W) + 1;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    ffba_pkg::t_state r_state, n_state;

    logic [ffba_pkg::BC_W-1:0]   r_bc;
    logic [ffba_pkg::BC_W-1:0]   r_n;
    logic [ffba_pkg::BC_W-1:0]   r_cnt;
    logic [ffba_pkg::BC_W-1:0]   r_ev_idx;
    logic                        r_pend;
    logic                        r_rd_vld;
    logic                        r_mode;
    logic [ffba_pkg::BIDX_W-1:0] r_idx_in;
    logic [ffba_pkg::REQ_W-1:0]  r_size;
    logic                        r_granted;
    logic [ffba_pkg::BIDX_W-1:0] r_number;
    logic [ffba_pkg::HOLE_W-1:0] r_acc;
    logic [NUM_BLOCKS-1:0]       r_valid;

    logic                        accept;
    logic                        issue;
    logic                        load_in_range;
    logic [SIZE_BITS-1:0]        load_val;
    logic [SIZE_BITS-1:0]        ev_val;
    logic                        fits;
    logic [SIZE_BITS-1:0]        ev_rem;
    logic [SUM_W-1:0]            acc_sum;
    logic [ffba_pkg::HOLE_W-1:0] n_acc;
    logic [ffba_pkg::BC_W-1:0]   bc_clip;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [SIZE_BITS-1:0]        ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [SIZE_BITS-1:0]        ram_rdata;

    ffba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign bc_clip     = (int'(r_bc) > NUM_BLOCKS) ? ffba_pkg::BC_W'(NUM_BLOCKS) : r_bc;
    assign issue       = (r_state == ffba_pkg::ST_SCAN) && (r_cnt < r_n);
    assign ram_raddr   = IDX_W'(r_cnt);

    assign load_in_range = int'(r_idx_in) < NUM_BLOCKS;
    assign load_val      = (CMP_W'(r_size) > CMP_W'(SIZE_MAX)) ? SIZE_MAX
                                                               : SIZE_BITS'(r_size);

    // Entries never written since reset read as zero.
    assign ev_val  = r_rd_vld ? ram_rdata : '0;
    assign fits    = r_pend && (r_mode == ffba_pkg::MODE_ALLOC) && !r_granted
                     && (CMP_W'(ev_val) >= CMP_W'(r_size));
    assign ev_rem  = fits ? SIZE_BITS'(CMP_W'(ev_val) - CMP_W'(r_size)) : ev_val;
    assign acc_sum = SUM_W'(r_acc) + SUM_W'(ev_rem);
    assign n_acc   = (acc_sum > SUM_W'(ffba_pkg::HOLE_MAX)) ? ffba_pkg::HOLE_MAX
                                                            : ffba_pkg::HOLE_W'(acc_sum);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_mode == ffba_pkg::MODE_LOAD) ? ffba_pkg::ST_WRITE
                                                              : ffba_pkg::ST_SCAN;
                end
            end
            ffba_pkg::ST_WRITE: begin
                n_state = ffba_pkg::ST_SCAN;
            end
            ffba_pkg::ST_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = ffba_pkg::ST_DONE;
                end
            end
            ffba_pkg::ST_DONE: begin
                n_state = ffba_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and RAM write control.
    always_comb begin
        busy      = 1'b1;
        o_done    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(r_ev_idx);
        ram_wdata = ev_rem;
        unique case (r_state)
            ffba_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            ffba_pkg::ST_WRITE: begin
                ram_we    = load_in_range;
                ram_waddr = IDX_W'(r_idx_in);
                ram_wdata = load_val;
            end
            ffba_pkg::ST_SCAN: begin
                ram_we = fits;
            end
            ffba_pkg::ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_granted      = r_granted;
    assign o_block_number = r_number;
    assign o_hole_total   = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::ST_IDLE;
            r_bc    <= '0;
            r_valid <= '0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bc <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (accept) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == ffba_pkg::ST_SCAN) begin
                r_pend <= issue;
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Request capture and scan datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= i_mode;
            r_idx_in  <= i_block_index;
            r_size    <= i_size;
            r_n       <= bc_clip;
            r_granted <= 1'b0;
            r_number  <= '0;
            r_acc     <= '0;
        end else if (r_state == ffba_pkg::ST_SCAN) begin
            r_ev_idx <= r_cnt;
            r_rd_vld <= r_valid[ram_raddr];
            if (r_pend) begin
                r_acc <= n_acc;
            end
            if (fits) begin
                r_granted <= 1'b1;
                r_number  <= ffba_pkg::BIDX_W'(r_ev_idx);
            end
        end
    end

    `ASSERT_CLK(a_done_to_idle, i_clk, i_rst_n, o_done |=> !busy, "done not followed by idle")
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept did not raise busy")
    `ASSERT_CLK(a_grant_alloc, i_clk, i_rst_n, (o_done && o_granted) |-> (r_mode == ffba_pkg::MODE_ALLOC), "grant on a load request")
    `ASSERT_CLK(a_nogrant_zero, i_clk, i_rst_n, (o_done && !o_granted) |-> (o_block_number == '0), "block number set without grant")
    `ASSERT_CLK(a_cnt_bound, i_clk, i_rst_n, (r_state == ffba_pkg::ST_SCAN) |-> (r_cnt <= r_n), "scan counter past blocks in use")

endmodule
